// ----- rtl/i2c_two_byte_write_master_core_defines.svh -----
// Assertion macros for the two-byte I2C write master.
// No dependencies; taken in by the RTL files that check their own logic.
`ifndef I2C_TWO_BYTE_WRITE_MASTER_CORE_DEFINES_SVH
`define I2C_TWO_BYTE_WRITE_MASTER_CORE_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset
`define I2CW_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset
`define I2CW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define I2CW_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define I2CW_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- rtl/i2cw_pkg.sv -----
// Package for the two-byte I2C write master: register map, reset values
// and the phase pattern functions. No dependencies.
package i2cw_pkg;

  localparam int unsigned PHASES     = 64;
  localparam int unsigned PHASE_W    = $clog2(PHASES);
  localparam int unsigned BYTE_PHASE = 28;  // 8 bits of 3 phases + 4-phase ack slot
  localparam int unsigned START_LEN  = 4;
  localparam int unsigned ADDR_W     = 3;
  localparam int unsigned DATA_W     = 32;

  localparam logic [7:0] BASE_RESET = 8'd64;
  localparam logic [7:0] MASK_RESET = 8'd62;
  localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(PHASES - 1);

  typedef enum logic {
    REG_ADDRESS_BASE = 1'b0,
    REG_ADDRESS_MASK = 1'b1
  } reg_index_t;

  typedef logic [PHASES-1:0] frame_t;

  // SCL level for each phase, bit p is phase p
  function automatic frame_t scl_pattern();
    frame_t v;
    int unsigned b;
    v = '0;
    v[0] = 1'b1; v[1] = 1'b1; v[2] = 1'b1; v[3] = 1'b0;
    for (int k = 0; k < 2; k++) begin
      b = START_LEN + k * BYTE_PHASE;
      for (int i = 0; i < 8; i++) begin
        v[b + 3*i]     = 1'b0;
        v[b + 3*i + 1] = 1'b1;
        v[b + 3*i + 2] = 1'b0;
      end
      v[b + 24] = 1'b0;
      v[b + 25] = 1'b0;
      v[b + 26] = 1'b1;
      v[b + 27] = 1'b0;
    end
    v[PHASES-4] = 1'b0; v[PHASES-3] = 1'b0; v[PHASES-2] = 1'b1; v[PHASES-1] = 1'b1;
    return v;
  endfunction

  localparam frame_t SCL_PATTERN = scl_pattern();

  // SDA level for each phase of one command, bit p is phase p
  function automatic frame_t sda_frame(input logic [7:0] first, input logic [7:0] second);
    frame_t v;
    logic [7:0] by;
    int unsigned b;
    v = '0;
    v[0] = 1'b1; v[1] = 1'b1; v[2] = 1'b0; v[3] = 1'b0;
    for (int k = 0; k < 2; k++) begin
      by = (k == 0) ? first : second;
      b  = START_LEN + k * BYTE_PHASE;
      for (int i = 0; i < 8; i++) begin
        v[b + 3*i]     = by[7-i];
        v[b + 3*i + 1] = by[7-i];
        v[b + 3*i + 2] = by[7-i];
      end
      // ack slot: hold the last bit, then release
      v[b + 24] = by[0];
      v[b + 25] = 1'b1;
      v[b + 26] = 1'b1;
      v[b + 27] = 1'b1;
    end
    v[PHASES-4] = 1'b1; v[PHASES-3] = 1'b0; v[PHASES-2] = 1'b0; v[PHASES-1] = 1'b1;
    return v;
  endfunction

endpackage

// ----- rtl/i2c_two_byte_write_master_core.sv -----
// Top level of the two-byte I2C write master: APB registers, command
// register and phase generator. Depends on i2cw_pkg and the defines header.
//
// Usage:
//  - Command channel (in_valid/in_ready, command_word): one transfer per
//    I2C write. The first byte is ((command_word >> 7) & address_mask) |
//    address_base, the second the low byte of command_word.
//  - Phase channel (out_valid/out_ready, clock_line, data_line,
//    last_phase): 64 transfers per command, one SCL/SDA level pair each:
//    start, two bytes MSB first with an unsampled ack slot, stop.
//    last_phase marks the final stop phase.
//  - APB port: address_base at 0x0, address_mask at 0x4; write while idle.
// Flow: a command passes through the command register and then the
// generator registers before its first phase is shown.
// A command gives one phase per cycle while out_ready is high, stepped by
// the single phase counter; one further command is held in the command
// register, so a steady stream gives back-to-back frames.
// Reset empties the command register and the generator and loads the
// register defaults (base 64, mask 62); the lines rest high between frames.
// When out_ready is low the current phase holds; once the command register
// is full, in_ready drops until the running frame ends.
`include "i2c_two_byte_write_master_core_defines.svh"

module i2c_two_byte_write_master_core (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [i2cw_pkg::ADDR_W-1:0]    paddr,
  input  logic [i2cw_pkg::DATA_W-1:0]    pwdata,
  output logic [i2cw_pkg::DATA_W-1:0]    prdata,
  output logic                           pready,
  // command channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [15:0]                    command_word,
  // phase channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           clock_line,
  output logic                           data_line,
  output logic                           last_phase
);

  logic [7:0]                    address_base;
  logic [7:0]                    address_mask;
  logic                          pend_valid;
  i2cw_pkg::frame_t              pend_frame;
  logic                          busy;
  i2cw_pkg::frame_t              frame;
  logic [i2cw_pkg::PHASE_W-1:0]  cnt;
  logic [7:0]                    first_byte;
  logic                          cfg_write;
  logic                          in_xfer;
  logic                          out_xfer;
  logic                          gen_load;
  i2cw_pkg::reg_index_t          reg_sel;

  // register access
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_sel   = i2cw_pkg::reg_index_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      address_base <= i2cw_pkg::BASE_RESET;
      address_mask <= i2cw_pkg::MASK_RESET;
    end else if (cfg_write) begin
      case (reg_sel)
        i2cw_pkg::REG_ADDRESS_BASE: address_base <= pwdata[7:0];
        i2cw_pkg::REG_ADDRESS_MASK: address_mask <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      i2cw_pkg::REG_ADDRESS_BASE: prdata = {24'd0, address_base};
      i2cw_pkg::REG_ADDRESS_MASK: prdata = {24'd0, address_mask};
      default:                    prdata = '0;
    endcase
  end

  // build the SDA frame at command transfer
  assign in_ready   = !pend_valid;
  assign in_xfer    = in_valid && in_ready;
  assign first_byte = (command_word[14:7] & address_mask) | address_base;

  // phase generator advances on every phase transfer
  assign out_xfer = out_valid && out_ready;
  assign gen_load = pend_valid && (!busy || (out_xfer && cnt == i2cw_pkg::LAST_PHASE));

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (in_xfer) begin
      pend_valid <= 1'b1;
    end else if (gen_load) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pend_frame <= i2cw_pkg::sda_frame(first_byte, command_word[7:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (gen_load) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (out_xfer) begin
      if (cnt == i2cw_pkg::LAST_PHASE) begin
        busy <= 1'b0;
      end
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (gen_load) begin
      frame <= pend_frame;
    end
  end

  // drive the current phase
  assign out_valid  = busy;
  assign clock_line = i2cw_pkg::SCL_PATTERN[cnt];
  assign data_line  = frame[cnt];
  assign last_phase = (cnt == i2cw_pkg::LAST_PHASE);

  // checks
  `I2CW_ASSERT_NEXT(a_cmd_held, clk, rst, in_xfer, pend_valid, "command not held after transfer")
  `I2CW_ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(cnt), "phase moved during stall")
  `I2CW_ASSERT_NEXT(a_phase_step, clk, rst, out_xfer && !last_phase, out_valid && cnt == $past(cnt) + 1'b1, "phase skipped or lost")
  `I2CW_ASSERT_NEXT(a_frame_end, clk, rst, out_xfer && last_phase && !pend_valid, !out_valid, "phase invented after frame end")

endmodule
